// ----- src/lsp_pkg.sv -----
// lsp_pkg: shared constants, codes, state encodings and handshake structs
// for the lifo stack with search and prime count
// depends on nothing; imported by every module in src

package lsp_pkg;

   // stack geometry
   localparam int DEPTH      = 64;
   localparam int VALUE_BITS = 16;
   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS   = PTR_BITS + 1;

   // prime test arithmetic: magnitude of a non-negative value and trial divisor
   localparam int MAG_BITS   = VALUE_BITS - 1;
   localparam int DIV_BITS   = (MAG_BITS + 2) / 2;
   localparam int SQ_BITS    = 2 * DIV_BITS;
   localparam int BCNT_BITS  = $clog2(MAG_BITS);

   // result field widths
   localparam int STATUS_W   = 2;
   localparam int DATA_W     = 16;
   localparam int POS_W      = 6;
   localparam int PRIMES_W   = 7;

   // commands
   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_PRIMES = 2'd3
   } cmd_type;

   // status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } stat_type;

   // top level sequencer
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_POP_DATA,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_PRM_RD,
      ST_PRM_LOAD,
      ST_PRM_WAIT,
      ST_FINISH
   } lsp_state_type;

   // prime test sequencer
   typedef enum logic [1:0] {
      PRM_IDLE,
      PRM_BOUND,
      PRM_DIV,
      PRM_DONE
   } prm_state_type;

   // remainder unit sequencer
   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // remainder unit status
   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] rem;
   } div_rsp_type;

   // prime test status
   typedef struct packed {
      logic done;
      logic is_prime;
   } prm_rsp_type;

   // one result word
   typedef struct packed {
      stat_type            status;
      logic [DATA_W-1:0]   data_out;
      logic                found;
      logic [POS_W-1:0]    position;
      logic [PRIMES_W-1:0] prime_count;
      logic                is_empty;
   } lsp_res_type;

endpackage

// ----- src/lsp_divider.sv -----
// lsp_divider: restoring remainder unit, one dividend bit per cycle
// depends on lsp_pkg

module lsp_divider
   import lsp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MAG_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0] divisor,
   output div_rsp_type         rsp
);

   div_state_type        state_ff, state_in;
   logic [BCNT_BITS-1:0] bcnt_ff, bcnt_in;
   logic [MAG_BITS-1:0]  num_ff, num_in;
   logic [DIV_BITS-1:0]  den_ff, den_in;
   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [DIV_BITS:0]    trial;
   logic [DIV_BITS:0]    diff;

   // one restoring step: bring down the next bit and subtract if it fits
   assign trial = {rem_ff, num_ff[MAG_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};

   // sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      bcnt_in  = bcnt_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               num_in   = dividend;
               den_in   = divisor;
               rem_in   = '0;
               bcnt_in  = BCNT_BITS'(MAG_BITS - 1);
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (trial >= {1'b0, den_ff}) begin
               rem_in = diff[DIV_BITS-1:0];
            end else begin
               rem_in = trial[DIV_BITS-1:0];
            end
            num_in  = {num_ff[MAG_BITS-2:0], 1'b0};
            bcnt_in = bcnt_ff - 1'b1;
            if (bcnt_ff == '0) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      bcnt_ff <= bcnt_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
   end

   assign rsp.done = (state_ff == DIV_DONE);
   assign rsp.rem  = rem_ff;

endmodule

// ----- src/lsp_prime_test.sv -----
// lsp_prime_test: trial division prime test of one stored value
// depends on lsp_pkg and lsp_divider

module lsp_prime_test
   import lsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] value,
   output prm_rsp_type           rsp
);

   prm_state_type       state_ff, state_in;
   logic [MAG_BITS-1:0] n_ff, n_in;
   logic [DIV_BITS-1:0] d_ff, d_in;
   logic                prime_ff, prime_in;
   logic [SQ_BITS-1:0]  sq;
   logic                div_start;
   div_rsp_type         div_rsp;

   // square of the trial divisor for the stop bound
   assign sq = SQ_BITS'(d_ff) * SQ_BITS'(d_ff);

   // shared remainder unit
   lsp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .rsp      (div_rsp)
   );

   // sequencer: values below two fail at once, else bound check, then one remainder per trial divisor
   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      d_in      = d_ff;
      prime_in  = prime_ff;
      div_start = 1'b0;
      unique case (state_ff)
         PRM_IDLE: begin
            if (start) begin
               n_in = value[MAG_BITS-1:0];
               d_in = DIV_BITS'(2);
               if (value[VALUE_BITS-1] || (value[MAG_BITS-1:0] < MAG_BITS'(2))) begin
                  prime_in = 1'b0;
                  state_in = PRM_DONE;
               end else begin
                  state_in = PRM_BOUND;
               end
            end
         end
         PRM_BOUND: begin
            if (sq > SQ_BITS'(n_ff)) begin
               prime_in = 1'b1;
               state_in = PRM_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = PRM_DIV;
            end
         end
         PRM_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.rem == '0) begin
                  prime_in = 1'b0;
                  state_in = PRM_DONE;
               end else begin
                  d_in     = d_ff + 1'b1;
                  state_in = PRM_BOUND;
               end
            end
         end
         PRM_DONE: begin
            state_in = PRM_IDLE;
         end
         default: begin
            state_in = PRM_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PRM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      d_ff     <= d_in;
      prime_ff <= prime_in;
   end

   assign rsp.done     = (state_ff == PRM_DONE);
   assign rsp.is_prime = prime_ff;

endmodule

// ----- src/lifo_stack_with_search_and_prime_count.sv -----
// lifo_stack_with_search_and_prime_count: top level, stack memory and command sequencer
// depends on lsp_pkg and lsp_prime_test (which holds lsp_divider)
//
//  channel | direction | tdata                         | tuser
//  req     | in        | value[15:0]                   | cmd[1:0]
//  rsp     | out       | data_out, found, position,    | status[1:0]
//          |           | prime_count, is_empty         |
//
// path to the result register: push writes and finishes, pop reads the top entry first (not
// when empty), search reads and compares one entry at a time from the top; count primes tests
// each stored entry in turn, values below two without division, else by trial division
// (up to 180 trial divisors) on the shared one-bit-per-cycle remainder unit
// reset empties the stack at once; stored entries are not cleared
// a finished result waits in the output register while a new word is taken; the next
// result then holds the sequencer until that register drains

module lifo_stack_with_search_and_prime_count
   import lsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value[15:0]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // data_out[15:0], found[16], position[22:17],
                                    // prime_count[29:23], is_empty[30], zero[31]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   lsp_state_type         state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   idx_ff, idx_in;
   logic [VALUE_BITS-1:0] key_ff, key_in;
   lsp_res_type           res_ff, res_in;
   lsp_res_type           rsp_res_ff, rsp_res_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [VALUE_BITS-1:0] stack_mem [DEPTH];
   logic [VALUE_BITS-1:0] mem_rd_ff;
   logic [PTR_BITS-1:0]   rd_addr;
   logic                  mem_we;
   logic                  req_fire;
   logic [CNT_BITS-1:0]   top_addr;
   logic [CNT_BITS-1:0]   srch_addr;
   logic                  prm_start;
   prm_rsp_type           prm_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && (state_ff == ST_IDLE);

   // read address: top entry, search walks down, prime count walks up
   assign top_addr  = count_ff - 1'b1;
   assign srch_addr = count_ff - 1'b1 - idx_ff;
   always_comb begin
      unique case (state_ff)
         ST_SRCH_RD: rd_addr = srch_addr[PTR_BITS-1:0];
         ST_PRM_RD:  rd_addr = idx_ff[PTR_BITS-1:0];
         default:    rd_addr = top_addr[PTR_BITS-1:0];
      endcase
   end

   // stack memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[count_ff[PTR_BITS-1:0]] <= req_tdata;
      end
      mem_rd_ff <= stack_mem[rd_addr];
   end

   // prime test with its shared remainder unit
   lsp_prime_test u_prime (
      .clock (clock),
      .reset (reset),
      .start (prm_start),
      .value (mem_rd_ff),
      .rsp   (prm_rsp)
   );

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      prm_start    = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_in        = '0;
               res_in.status = STAT_OK;
               key_in        = req_tdata;
               idx_in        = '0;
               unique case (cmd_type'(req_tuser))
                  CMD_PUSH: begin
                     if (count_ff == CNT_BITS'(DEPTH)) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     state_in = ST_FINISH;
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                        state_in      = ST_FINISH;
                     end else begin
                        state_in = ST_POP_RD;
                     end
                  end
                  CMD_SEARCH: state_in = ST_SRCH_RD;
                  CMD_PRIMES: state_in = ST_PRM_RD;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_POP_RD: begin
            state_in = ST_POP_DATA;
         end
         ST_POP_DATA: begin
            res_in.data_out = DATA_W'(mem_rd_ff);
            count_in        = count_ff - 1'b1;
            state_in        = ST_FINISH;
         end
         // search: read, then compare, one entry at a time from the top down
         ST_SRCH_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            if (mem_rd_ff == key_ff) begin
               res_in.found    = 1'b1;
               res_in.position = POS_W'(idx_ff);
               state_in        = ST_FINISH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SRCH_RD;
            end
         end
         // prime count: test each stored entry in turn
         ST_PRM_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PRM_LOAD;
            end
         end
         ST_PRM_LOAD: begin
            prm_start = 1'b1;
            state_in  = ST_PRM_WAIT;
         end
         ST_PRM_WAIT: begin
            if (prm_rsp.done) begin
               if (prm_rsp.is_prime) begin
                  res_in.prime_count = res_ff.prime_count + 1'b1;
               end
               idx_in   = idx_ff + 1'b1;
               state_in = ST_PRM_RD;
            end
         end
         // hand the result to the output register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_res_in          = res_ff;
               rsp_res_in.is_empty = (count_ff == '0);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      key_ff     <= key_in;
      res_ff     <= res_in;
      rsp_res_ff <= rsp_res_in;
   end

   // result word packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {1'b0, rsp_res_ff.is_empty, rsp_res_ff.prime_count,
                        rsp_res_ff.position, rsp_res_ff.found, rsp_res_ff.data_out};

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for the lifo stack with search and prime count
// drives command words on req_, checks every reply word on rsp_ against a local stack model or an opening table row
// depends on lsp_pkg and the block under test lifo_stack_with_search_and_prime_count

module tb
   import lsp_pkg::*;
();

   localparam int RAND_ITEMS     = 1500;
   localparam int WATCHDOG_LIMIT = 1000000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int OPENING_ROWS   = 25;

   // one row of the opening stimulus table
   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] value;
      logic        typed;
      lsp_res_type res;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = CMD_PUSH;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // local copy of the stack
   logic [15:0] stack_mem [DEPTH];
   int          stack_fill;

   lsp_res_type  reply_queue [$];
   lsp_res_type  want_word;
   lsp_res_type  got_word;
   stim_row_type opening_rows [OPENING_ROWS];

   int send_idle_pct;
   int stall_pct;
   int faults;
   int quiet_cycles;
   int replies_checked;
   int rand_sent;
   int n_push, n_push_full, n_pop, n_pop_empty, n_search, n_hits, n_primes;
   int deepest, top_primes;

   lifo_stack_with_search_and_prime_count dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // exactly two positive divisors
   function automatic bit value_is_prime(logic [15:0] v);
      int n;
      int d;
      n = int'($signed(v));
      if (n < 2) return 1'b0;
      for (d = 2; d * d <= n; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // apply one command to the local stack and form its reply word
   function automatic lsp_res_type apply_stack_cmd(cmd_type c, logic [15:0] v);
      lsp_res_type r;
      int          i;
      r = '0;
      r.status = STAT_OK;
      case (c)
         CMD_PUSH: begin
            n_push++;
            if (stack_fill >= DEPTH) begin
               r.status = STAT_FULL;
               n_push_full++;
            end else begin
               stack_mem[stack_fill] = v;
               stack_fill++;
            end
         end
         CMD_POP: begin
            n_pop++;
            if (stack_fill == 0) begin
               r.status = STAT_EMPTY;
               n_pop_empty++;
            end else begin
               stack_fill--;
               r.data_out = stack_mem[stack_fill];
            end
         end
         CMD_SEARCH: begin
            n_search++;
            // first match counted from the top
            for (i = stack_fill - 1; i >= 0 && !r.found; i--) begin
               if (stack_mem[i] == v) begin
                  r.found    = 1'b1;
                  r.position = POS_W'(stack_fill - 1 - i);
               end
            end
            if (r.found) n_hits++;
         end
         default: begin
            n_primes++;
            for (i = 0; i < stack_fill; i++) begin
               if (value_is_prime(stack_mem[i])) r.prime_count++;
            end
            if (r.prime_count > top_primes) top_primes = r.prime_count;
         end
      endcase
      r.is_empty = (stack_fill == 0);
      if (stack_fill > deepest) deepest = stack_fill;
      return r;
   endfunction

   function automatic stim_row_type row(cmd_type c, logic [15:0] v, logic t, stat_type s,
                                        logic [15:0] d, logic e);
      stim_row_type r;
      r = '0;
      r.cmd          = c;
      r.value        = v;
      r.typed        = t;
      r.res.status   = s;
      r.res.data_out = d;
      r.res.is_empty = e;
      return r;
   endfunction

   function automatic logic [15:0] small_prime();
      logic [15:0] v;
      do v = 16'($urandom_range(2, 250)); while (!value_is_prime(v));
      return v;
   endfunction

   function automatic logic [15:0] small_value();
      int n;
      n = int'($urandom_range(0, 208)) - 8;
      return n[15:0];
   endfunction

   // mix of small values, corners, small primes and full-range words
   function automatic logic [15:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return small_value();
      if (r < 55) begin
         case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h8001;
            2: return 16'hFFFF;
            3: return 16'd0;
            4: return 16'd1;
            5: return 16'd2;
            6: return 16'd3;
            7: return 16'd4;
            8: return 16'h7FFF;
            default: return 16'd32749;
         endcase
      end
      if (r < 70) return small_prime();
      return 16'($urandom_range(0, 65535));
   endfunction

   // search key: mostly something already stored
   function automatic logic [15:0] search_key();
      if (stack_fill > 0 && $urandom_range(0, 99) < 60)
         return stack_mem[$urandom_range(0, stack_fill - 1)];
      return pick_value();
   endfunction

   task automatic log_fault(string what);
      faults++;
      if (faults <= 10) $display("%s", what);
   endtask

   // hand one command word over and queue its reply
   task automatic issue(cmd_type c, logic [15:0] v, logic typed, lsp_res_type typed_res);
      lsp_res_type pred;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      pred = apply_stack_cmd(c, v);
      reply_queue.push_back(typed ? typed_res : pred);
   endtask

   // reply side: check each accepted word, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_word.status      = stat_type'(rsp_tuser);
         got_word.data_out    = rsp_tdata[15:0];
         got_word.found       = rsp_tdata[16];
         got_word.position    = rsp_tdata[22:17];
         got_word.prime_count = rsp_tdata[29:23];
         got_word.is_empty    = rsp_tdata[30];
         if (reply_queue.size() == 0) begin
            log_fault($sformatf("reply word with nothing outstanding: tuser %h tdata %h",
                                rsp_tuser, rsp_tdata));
         end else begin
            want_word = reply_queue.pop_front();
            replies_checked++;
            if (got_word !== want_word || rsp_tdata[31] !== 1'b0)
               log_fault($sformatf({"reply %0d mismatch: want st %0d data %h found %b pos %0d",
                                    " primes %0d empty %b / got st %0d data %h found %b",
                                    " pos %0d primes %0d empty %b pad %b"},
                                   replies_checked, want_word.status, want_word.data_out,
                                   want_word.found, want_word.position,
                                   want_word.prime_count, want_word.is_empty,
                                   got_word.status, got_word.data_out, got_word.found,
                                   got_word.position, got_word.prime_count,
                                   got_word.is_empty, rsp_tdata[31]));
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no word moved for %0d cycles, %0d replies outstanding",
                  quiet_cycles, reply_queue.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int i;
      int k;
      int r;
      int len;
      int fill_mode;
      cmd_type c;

      stack_fill    = 0;
      send_idle_pct = 0;
      stall_pct     = 0;

      // opening table: empty-stack cases, extremes, primes and search, then a full drain
      opening_rows = '{
         row(CMD_POP,    16'd0,     1'b1, STAT_EMPTY, 16'd0,  1'b1),
         row(CMD_SEARCH, 16'd0,     1'b1, STAT_OK,    16'd0,  1'b1),
         row(CMD_PRIMES, 16'd0,     1'b1, STAT_OK,    16'd0,  1'b1),
         row(CMD_PUSH,   16'h8000,  1'b1, STAT_OK,    16'd0,  1'b0),
         row(CMD_PUSH,   16'h7FFF,  1'b1, STAT_OK,    16'd0,  1'b0),
         row(CMD_PUSH,   16'd0,     1'b1, STAT_OK,    16'd0,  1'b0),
         row(CMD_PUSH,   16'd1,     1'b1, STAT_OK,    16'd0,  1'b0),
         row(CMD_PUSH,   16'd2,     1'b1, STAT_OK,    16'd0,  1'b0),
         row(CMD_PUSH,   16'd32749, 1'b1, STAT_OK,    16'd0,  1'b0),
         row(CMD_PUSH,   16'hFFFE,  1'b1, STAT_OK,    16'd0,  1'b0),
         row(CMD_PUSH,   16'd3,     1'b1, STAT_OK,    16'd0,  1'b0),
         row(CMD_PRIMES, 16'd0,     1'b0, STAT_OK,    16'd0,  1'b0),
         row(CMD_SEARCH, 16'h7FFF,  1'b0, STAT_OK,    16'd0,  1'b0),
         row(CMD_SEARCH, 16'h8000,  1'b0, STAT_OK,    16'd0,  1'b0),
         row(CMD_SEARCH, 16'd3,     1'b0, STAT_OK,    16'd0,  1'b0),
         row(CMD_SEARCH, 16'd12345, 1'b0, STAT_OK,    16'd0,  1'b0),
         row(CMD_POP,    16'd0,     1'b1, STAT_OK,    16'd3,  1'b0),
         row(CMD_POP,    16'd0,     1'b0, STAT_OK,    16'd0,  1'b0),
         row(CMD_POP,    16'd0,     1'b0, STAT_OK,    16'd0,  1'b0),
         row(CMD_POP,    16'd0,     1'b0, STAT_OK,    16'd0,  1'b0),
         row(CMD_POP,    16'd0,     1'b0, STAT_OK,    16'd0,  1'b0),
         row(CMD_POP,    16'd0,     1'b0, STAT_OK,    16'd0,  1'b0),
         row(CMD_POP,    16'd0,     1'b0, STAT_OK,    16'd0,  1'b0),
         row(CMD_POP,    16'd0,     1'b1, STAT_OK,    16'h8000, 1'b1),
         row(CMD_POP,    16'd0,     1'b1, STAT_EMPTY, 16'd0,  1'b1)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < OPENING_ROWS; i++)
         issue(opening_rows[i].cmd, opening_rows[i].value, opening_rows[i].typed,
               opening_rows[i].res);

      // random part: fills, drains and mixed bursts, over four idling phases
      rand_sent = 0;
      while (rand_sent < RAND_ITEMS) begin
         case ((rand_sent * 4) / RAND_ITEMS)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 81; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         r = $urandom_range(0, 99);
         if (r < 8) begin
            // fill to the brim, push past full, then inspect
            fill_mode = $urandom_range(0, 1);
            while (stack_fill < DEPTH) begin
               issue(CMD_PUSH, fill_mode ? small_prime() : small_value(), 1'b0, '0);
               rand_sent++;
            end
            len = $urandom_range(1, 3);
            for (k = 0; k < len; k++) begin
               issue(CMD_PUSH, pick_value(), 1'b0, '0);
               rand_sent++;
            end
            issue(CMD_PRIMES, 16'($urandom_range(0, 65535)), 1'b0, '0);
            issue(CMD_SEARCH, search_key(), 1'b0, '0);
            issue(CMD_SEARCH, pick_value(), 1'b0, '0);
            rand_sent += 3;
         end else if (r < 16) begin
            // drain to empty, pop past empty, then inspect the empty stack
            while (stack_fill > 0) begin
               issue(CMD_POP, 16'($urandom_range(0, 65535)), 1'b0, '0);
               rand_sent++;
            end
            len = $urandom_range(1, 2);
            for (k = 0; k < len; k++) begin
               issue(CMD_POP, 16'($urandom_range(0, 65535)), 1'b0, '0);
               rand_sent++;
            end
            issue(CMD_SEARCH, pick_value(), 1'b0, '0);
            issue(CMD_PRIMES, 16'($urandom_range(0, 65535)), 1'b0, '0);
            rand_sent += 2;
         end else begin
            // mixed burst
            len = $urandom_range(6, 20);
            for (k = 0; k < len; k++) begin
               r = $urandom_range(0, 99);
               if (r < 36)      c = CMD_PUSH;
               else if (r < 66) c = CMD_POP;
               else if (r < 92) c = CMD_SEARCH;
               else             c = CMD_PRIMES;
               case (c)
                  CMD_PUSH:   issue(c, pick_value(), 1'b0, '0);
                  CMD_SEARCH: issue(c, search_key(), 1'b0, '0);
                  default:    issue(c, 16'($urandom_range(0, 65535)), 1'b0, '0);
               endcase
               rand_sent++;
            end
         end
      end
      req_tvalid <= 1'b0;

      // let every reply arrive, then watch for strays
      while (reply_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d pushes (%0d on full), %0d pops (%0d on empty),",
               n_push, n_push_full, n_pop, n_pop_empty);
      $display("%0d searches (%0d hits), %0d prime counts, deepest stack %0d,",
               n_search, n_hits, n_primes, deepest);
      $display("largest prime count %0d, %0d replies checked, %0d faults",
               top_primes, replies_checked, faults);
      if (faults == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/lsp_pkg.sv
src/lsp_divider.sv
src/lsp_prime_test.sv
src/lifo_stack_with_search_and_prime_count.sv
tb/tb.sv
